// ===== rtl/rmth_pkg.sv =====
// package: sizes and control struct for the running median block
package rmth_pkg;
   localparam int CAPACITY   = 4096;
   localparam int DATA_WIDTH = 32;
   localparam int HALF_DEPTH = (CAPACITY + 1) / 2;
   localparam int ADDR_W     = $clog2(HALF_DEPTH);
   localparam int CNT_W      = $clog2(HALF_DEPTH + 1);
   localparam int TOT_W      = $clog2(CAPACITY + 1);

   typedef struct packed {
      logic              en;
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [31:0]       wdata;
   } mem_req_type;
endpackage

// ===== rtl/rmth_ram.sv =====
// generic single-port ram with registered read
module rmth_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) mem[addr] <= wdata;
         rdata_ff <= mem[addr];
      end
   end
   assign rdata = rdata_ff;
endmodule

// ===== rtl/running_median_two_heaps_top.sv =====
// top level: running median over two heaps held in two rams
// Each accepted sample goes into a max-heap of the lower half or a min-heap of the
// upper half. Both heaps sit in single-port rams with registered read, and only one
// sample is in flight at a time. A sift-down level reads two children, picks the
// outranking one, compares it with the key and writes; a sift-up level reads the
// parent, compares and writes. Each heap ram has 2048 entries. The next sample can
// be taken in the same cycle that the result appears. A sample offered when CAPACITY
// samples are held is dropped and flagged in rsp_tuser bit 0; its result is issued
// from S_OUT without touching the heaps. The heap tops are mirrored in registers, and
// one result can wait in the output register while the next sample is processed.
module running_median_two_heaps_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // median_twice[32:0], count[45:33], zero fill
   output logic        rsp_tuser    // full_res
);
   localparam int AW = rmth_pkg::ADDR_W;
   localparam int CW = rmth_pkg::CNT_W;
   localparam int DW = rmth_pkg::DATA_WIDTH;
   localparam int TW = rmth_pkg::TOT_W;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DRD   = 4'd1; // read first child
   localparam logic [3:0] S_DRD2  = 4'd2; // pick the outranking child
   localparam logic [3:0] S_DCMP  = 4'd3; // compare child and key
   localparam logic [3:0] S_UINIT = 4'd4;
   localparam logic [3:0] S_URD   = 4'd5; // read parent
   localparam logic [3:0] S_UCMP  = 4'd6;
   localparam logic [3:0] S_OUT   = 4'd7;
   localparam logic [3:0] S_DWAIT = 4'd8; // first child arrives

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] lcnt_ff, lcnt_in, ucnt_ff, ucnt_in;
   logic [31:0]   ltop_ff, ltop_in, utop_ff, utop_in;
   logic          side_ff, side_in;   // 1: sift in upper (min) heap
   logic [31:0]   key_ff, key_in, mov_ff, mov_in, c1_ff, c1_in;
   logic [AW:0]   pos_ff, pos_in, n_ff, n_in, chs_ff, chs_in;
   logic          full_ff, full_in, vld_ff, vld_in;
   logic [32:0]   med_ff, med_in;
   logic [TW-1:0] rcnt_ff, rcnt_in;
   logic          rfull_ff, rfull_in;

   rmth_pkg::mem_req_type lreq, ureq, areq;
   logic [31:0] lrd, urd, rd;

   rmth_ram #(.WIDTH(32), .DEPTH(rmth_pkg::HALF_DEPTH)) u_lower (
      .clock(clock), .en(lreq.en), .we(lreq.we), .addr(lreq.addr),
      .wdata(lreq.wdata), .rdata(lrd));
   rmth_ram #(.WIDTH(32), .DEPTH(rmth_pkg::HALF_DEPTH)) u_upper (
      .clock(clock), .en(ureq.en), .we(ureq.we), .addr(ureq.addr),
      .wdata(ureq.wdata), .rdata(urd));

   assign rd = side_ff ? urd : lrd;

   function automatic logic outr(input logic [31:0] a, input logic [31:0] b,
                                 input logic minh);
      outr = minh ? ($signed(a) < $signed(b)) : ($signed(a) > $signed(b));
   endfunction

   logic [31:0]   x;
   logic [AW:0]   c;
   logic [TW-1:0] total;
   assign x = {{(33-DW){req_tdata[DW-1]}}, req_tdata[DW-2:0]};
   assign total = TW'(lcnt_ff) + TW'(ucnt_ff);
   assign req_tready = (state_ff == S_IDLE);
   assign c = {pos_ff[AW-1:0], 1'b1};

   always_comb begin
      state_in = state_ff; lcnt_in = lcnt_ff; ucnt_in = ucnt_ff;
      ltop_in = ltop_ff; utop_in = utop_ff; side_in = side_ff;
      key_in = key_ff; mov_in = mov_ff; c1_in = c1_ff; pos_in = pos_ff;
      n_in = n_ff; chs_in = chs_ff; full_in = full_ff; vld_in = vld_ff;
      med_in = med_ff; rcnt_in = rcnt_ff; rfull_in = rfull_ff;
      areq = '0;
      if (vld_ff && rsp_tready) vld_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               full_in = 1'b0;
               if (total >= TW'(rmth_pkg::CAPACITY)) begin
                  full_in = 1'b1; state_in = S_OUT;
               end else if (ucnt_ff > lcnt_ff) begin
                  if ($signed(x) > $signed(utop_ff)) begin
                     // replace upper top, old top moves down
                     side_in = 1'b1; key_in = x; mov_in = utop_ff;
                     n_in = (AW+1)'(ucnt_ff); pos_in = '0;
                     state_in = S_DRD;
                  end else begin
                     side_in = 1'b0; mov_in = x; state_in = S_UINIT;
                  end
               end else begin
                  if (lcnt_ff != '0 && $signed(x) < $signed(ltop_ff)) begin
                     side_in = 1'b0; key_in = x; mov_in = ltop_ff;
                     n_in = (AW+1)'(lcnt_ff); pos_in = '0;
                     state_in = S_DRD;
                  end else begin
                     side_in = 1'b1; mov_in = x; state_in = S_UINIT;
                  end
               end
            end
         end
         S_DRD: begin
            if (c >= n_ff) begin
               areq = '{en: 1'b1, we: 1'b1, addr: pos_ff[AW-1:0], wdata: key_ff};
               side_in = ~side_ff; state_in = S_UINIT;
            end else begin
               areq = '{en: 1'b1, we: 1'b0, addr: c[AW-1:0], wdata: '0};
               state_in = S_DWAIT;
            end
         end
         S_DWAIT: begin
            c1_in = rd;
            if (c + 1'b1 < n_ff) begin
               areq = '{en: 1'b1, we: 1'b0, addr: AW'(c + 1'b1), wdata: '0};
               state_in = S_DRD2;
            end else begin
               chs_in = c; state_in = S_DCMP;
            end
         end
         S_DRD2: begin
            // second child now valid on rd
            if (outr(rd, c1_ff, side_ff)) begin
               c1_in = rd; chs_in = c + 1'b1;
            end else chs_in = c;
            state_in = S_DCMP;
         end
         S_DCMP: begin
            if (!outr(c1_ff, key_ff, side_ff)) begin
               areq = '{en: 1'b1, we: 1'b1, addr: pos_ff[AW-1:0], wdata: key_ff};
               side_in = ~side_ff; state_in = S_UINIT;
            end else begin
               areq = '{en: 1'b1, we: 1'b1, addr: pos_ff[AW-1:0], wdata: c1_ff};
               pos_in = chs_ff; state_in = S_DRD;
            end
         end
         S_UINIT: begin
            pos_in = side_ff ? (AW+1)'(ucnt_ff) : (AW+1)'(lcnt_ff);
            if (side_ff) ucnt_in = ucnt_ff + 1'b1; else lcnt_in = lcnt_ff + 1'b1;
            state_in = S_URD;
         end
         S_URD: begin
            if (pos_ff == '0) begin
               areq = '{en: 1'b1, we: 1'b1, addr: '0, wdata: mov_ff};
               state_in = S_OUT;
            end else begin
               areq = '{en: 1'b1, we: 1'b0, addr: AW'((pos_ff - 1'b1) >> 1), wdata: '0};
               state_in = S_UCMP;
            end
         end
         S_UCMP: begin
            if (!outr(mov_ff, rd, side_ff)) begin
               areq = '{en: 1'b1, we: 1'b1, addr: pos_ff[AW-1:0], wdata: mov_ff};
               state_in = S_OUT;
            end else begin
               areq = '{en: 1'b1, we: 1'b1, addr: pos_ff[AW-1:0], wdata: rd};
               pos_in = (pos_ff - 1'b1) >> 1;
               state_in = S_URD;
            end
         end
         S_OUT: begin
            // wait until the output register is free
            if (!vld_ff || rsp_tready) begin
               if (ucnt_ff > lcnt_ff)
                  med_in = {utop_ff[31], utop_ff} + {utop_ff[31], utop_ff};
               else
                  med_in = {utop_ff[31], utop_ff} + {ltop_ff[31], ltop_ff};
               rcnt_in = total; rfull_in = full_ff;
               vld_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // any write to the root refreshes the mirrored top
      if (areq.en && areq.we && areq.addr == '0) begin
         if (side_ff) utop_in = areq.wdata; else ltop_in = areq.wdata;
      end
   end

   always_comb begin
      lreq = '0; ureq = '0;
      if (side_ff) ureq = areq; else lreq = areq;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; lcnt_ff <= '0; ucnt_ff <= '0; vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in; lcnt_ff <= lcnt_in; ucnt_ff <= ucnt_in; vld_ff <= vld_in;
      end
      ltop_ff <= ltop_in; utop_ff <= utop_in; side_ff <= side_in; key_ff <= key_in;
      mov_ff <= mov_in; c1_ff <= c1_in; pos_ff <= pos_in; n_ff <= n_in;
      chs_ff <= chs_in; full_ff <= full_in; med_ff <= med_in;
      rcnt_ff <= rcnt_in; rfull_ff <= rfull_in;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = {2'b00, rcnt_ff, med_ff};
   assign rsp_tuser  = rfull_ff;
endmodule

// ===== sim/testbench.sv =====
// testbench: running median block checked against a dual-heap predictor
`timescale 1ns / 1ps

module testbench;
   localparam int LIMIT_CYCLES = 2000000;

   typedef struct packed {
      logic signed [32:0] median_twice;
      logic [12:0]        count;
      logic               full_res;
   } median_rsp_type;

   typedef struct {
      logic [31:0]    sample;
      logic           has_fixed;
      median_rsp_type fixed;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tuser;

   running_median_two_heaps_top u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   logic signed [31:0] lo_heap [rmth_pkg::HALF_DEPTH];
   logic signed [31:0] hi_heap [rmth_pkg::HALF_DEPTH];
   int unsigned        lo_n, hi_n;
   median_rsp_type     median_queue [$];
   logic               fixed_queue [$];
   median_rsp_type     fixed_vals [$];
   int                 errors = 0;
   int                 cycles = 0;
   bit                 stim_done = 0;
   bit                 hold_off = 0;

   function automatic bit ranks_above(logic signed [31:0] a, logic signed [31:0] b,
                                      bit is_max);
      return is_max ? (a > b) : (a < b);
   endfunction

   function automatic void heap_push_root(ref logic signed [31:0] h [rmth_pkg::HALF_DEPTH],
                                          input int unsigned n,
                                          input logic signed [31:0] key, input bit is_max);
      int unsigned pos, c;
      pos = 0;
      forever begin
         c = pos * 2 + 1;
         if (c >= n) break;
         if (c + 1 < n && ranks_above(h[c+1], h[c], is_max)) c++;
         if (!ranks_above(h[c], key, is_max)) break;
         h[pos] = h[c];
         pos = c;
      end
      h[pos] = key;
   endfunction

   function automatic void heap_append(ref logic signed [31:0] h [rmth_pkg::HALF_DEPTH],
                                       input int unsigned n,
                                       input logic signed [31:0] key, input bit is_max);
      int unsigned pos, p;
      pos = n;
      while (pos > 0) begin
         p = (pos - 1) / 2;
         if (!ranks_above(key, h[p], is_max)) break;
         h[pos] = h[p];
         pos = p;
      end
      h[pos] = key;
   endfunction

   function automatic median_rsp_type add_sample(logic signed [31:0] x_in);
      median_rsp_type r;
      logic signed [31:0] x, t;
      x = x_in;
      r.full_res = 1'b0;
      if (lo_n + hi_n >= rmth_pkg::CAPACITY) begin
         r.full_res = 1'b1;
      end else if (hi_n > lo_n) begin
         if (x > hi_heap[0]) begin
            t = hi_heap[0];
            heap_push_root(hi_heap, hi_n, x, 1'b0);
            x = t;
         end
         heap_append(lo_heap, lo_n, x, 1'b1);
         lo_n++;
      end else begin
         if (lo_n > 0 && x < lo_heap[0]) begin
            t = lo_heap[0];
            heap_push_root(lo_heap, lo_n, x, 1'b1);
            x = t;
         end
         heap_append(hi_heap, hi_n, x, 1'b0);
         hi_n++;
      end
      if (hi_n == 0) r.median_twice = '0;
      else if (hi_n > lo_n) r.median_twice = 33'(2 * 64'(signed'(hi_heap[0])));
      else r.median_twice = 33'(64'(signed'(hi_heap[0])) + 64'(signed'(lo_heap[0])));
      r.count = 13'(lo_n + hi_n);
      return r;
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      errors++;
      $display("mismatch %s: got %0d expected %0d", what, got, want);
   endtask

   // sender: valid stays high across back-to-back items
   task automatic send(input logic [31:0] s);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      median_queue.push_back(add_sample(s));
      @(negedge clock);
   endtask

   stim_row_type rows [$];

   task automatic add_row(input logic [31:0] s, input bit hf, input median_rsp_type f);
      stim_row_type r;
      r.sample = s; r.has_fixed = hf; r.fixed = f;
      rows.push_back(r);
   endtask

   initial begin
      median_rsp_type z;
      logic [31:0] s;
      int k, mode;
      z = '0;
      lo_n = 0; hi_n = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // first sample: median is the sample doubled
      add_row(32'h8000_0000, 1, '{33'sh1_0000_0000, 13'd1, 1'b0});
      add_row(32'h8000_0000, 1, '{33'sh1_0000_0000, 13'd2, 1'b0});
      add_row(32'h7fff_ffff, 0, z);
      add_row(32'h7fff_ffff, 0, z);
      add_row(32'h7fff_ffff, 0, z);
      add_row(32'h0000_0000, 0, z);
      add_row(32'hffff_ffff, 0, z);
      add_row(32'h0000_0001, 0, z);
      add_row(32'h0000_0001, 0, z);
      add_row(32'h0000_0001, 0, z);
      add_row(32'haaaa_aaaa, 0, z);
      add_row(32'h5555_5555, 0, z);
      add_row(32'h8000_0001, 0, z);
      add_row(32'h7fff_fffe, 0, z);
      foreach (rows[i]) begin
         fixed_queue.push_back(rows[i].has_fixed);
         if (rows[i].has_fixed) fixed_vals.push_back(rows[i].fixed);
         send(rows[i].sample);
      end
      // random: mostly varied, some narrow ranges to force ties
      for (k = 0; k < 1336; k++) begin
         mode = $urandom_range(0, 3);
         if (mode == 0) s = 32'($urandom_range(0, 7)) - 32'd3;
         else s = $urandom;
         if (k == 600) hold_off = 1;
         fixed_queue.push_back(1'b0);
         send(s);
      end
      req_tvalid <= 1'b0;
      stim_done = 1;
   end

   // receiver with random stalls and one long hold-off
   initial begin
      int gap, held;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_tready <= 1'b0;
            held = 0;
            while (held < 300) begin
               @(negedge clock);
               held++;
            end
            hold_off = 0;
         end
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
         if ($urandom_range(0, 3) == 0) gap = 0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // checker
   always @(posedge clock) begin
      median_rsp_type want, got;
      logic hf;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.median_twice = rsp_tdata[32:0];
         got.count = rsp_tdata[45:33];
         got.full_res = rsp_tuser;
         if (median_queue.size() == 0) begin
            report("unexpected transfer", got.count, -1);
         end else begin
            want = median_queue.pop_front();
            hf = fixed_queue.size() ? fixed_queue.pop_front() : 1'b0;
            if (hf && fixed_vals.size()) want = fixed_vals.pop_front();
            if (got.median_twice !== want.median_twice)
               report("median_twice", got.median_twice, want.median_twice);
            if (got.count !== want.count) report("count", got.count, want.count);
            if (got.full_res !== want.full_res) report("full_res", got.full_res, want.full_res);
         end
      end
   end

   initial begin
      while (!(stim_done && median_queue.size() == 0) && cycles < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      if (cycles >= LIMIT_CYCLES) begin
         $display("running_median_two_heaps_top verification failed");
      end else begin
         repeat (100) @(posedge clock);
         if (errors == 0 && median_queue.size() == 0)
            $display("running_median_two_heaps_top verification clean");
         else
            $display("running_median_two_heaps_top verification failed");
      end
      $finish;
   end
endmodule
